@@ rtl/text_console_writer_assert.svh @@
// assertion macros for the text console writer
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef SYNTHESIS
`define TCW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tcw assertion failed");
`define TCW_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("tcw forbidden condition");
`else
`define TCW_ASSERT(lbl, prop)
`define TCW_NEVER(lbl, expr)
`endif

`endif

@@ rtl/tcw_pkg.sv @@
// shared types, constants and helpers for the text console writer
// no dependencies
package tcw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STEP = 4;
  localparam int CELLS    = COLUMNS * ROWS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;
  localparam int CLR_W  = 4;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  localparam logic CFG_FOREGROUND = 1'b0;
  localparam logic CFG_BACKGROUND = 1'b1;

  localparam logic [2:0] CMD_GLYPH   = 3'd0;
  localparam logic [2:0] CMD_NEWLINE = 3'd1;
  localparam logic [2:0] CMD_TAB     = 3'd2;
  localparam logic [2:0] CMD_CLEAR   = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;
  localparam logic [2:0] CMD_NOP     = 3'd5;

  typedef struct packed {
    logic [1:0]        mode;
    logic [7:0]        character;
    logic [ADDR_W-1:0] cell_address;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [CELL_W-1:0] cell_data;
  } out_item_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [7:0]        character;
    logic [ADDR_W-1:0] cell_address;
  } cmd_t;

  typedef struct packed {
    logic [CLR_W-1:0] fg;
    logic [CLR_W-1:0] bg;
  } colour_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [7:0] ch, input colour_t clr);
    make_cell = {clr.bg, clr.fg, ch};
  endfunction

endpackage

@@ rtl/tcw_front.sv @@
// front end: accepts transactions and classifies them into commands
// depends on tcw_pkg
module tcw_front (
  input  logic                  start,
  input  tcw_pkg::in_item_t     in_item,
  input  tcw_pkg::queue_status_t q_status,
  output logic                  busy,
  output logic                  push,
  output tcw_pkg::cmd_t         cmd
);
  import tcw_pkg::*;

  assign busy = q_status.full;
  assign push = start && !q_status.full;

  always_comb begin
    cmd.character    = in_item.character;
    cmd.cell_address = in_item.cell_address;
    cmd.kind         = CMD_NOP;
    unique case (in_item.mode)
      MODE_PUT: begin
        if (in_item.character == CH_NEWLINE) begin
          cmd.kind = CMD_NEWLINE;
        end else if (in_item.character == CH_TAB) begin
          cmd.kind = CMD_TAB;
        end else begin
          cmd.kind = CMD_GLYPH;
        end
      end
      MODE_CLEAR: begin
        cmd.kind = CMD_CLEAR;
      end
      MODE_READ: begin
        if (in_item.cell_address < ADDR_W'(CELLS)) begin
          cmd.kind = CMD_READ;
        end
      end
      default: begin
        cmd.kind = CMD_NOP;
      end
    endcase
  end

endmodule

@@ rtl/tcw_cmd_queue.sv @@
// two-entry command queue between the front end and the executor
// depends on tcw_pkg
module tcw_cmd_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  tcw_pkg::cmd_t          push_cmd,
  input  logic                   pop,
  output tcw_pkg::cmd_t          head_cmd,
  output tcw_pkg::queue_status_t status
);
  import tcw_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign status.valid = (count_r != 2'd0);
  assign status.full  = (count_r == 2'd2);
  assign head_cmd     = entry_r[rd_ptr_r];

  assign do_push = push && !status.full;
  assign do_pop  = pop && status.valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/tcw_back.sv @@
// executor: cursor, frame store, scroll and clear sweeps, cell reads
// depends on tcw_pkg and text_console_writer_assert.svh
module tcw_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tcw_pkg::colour_t       colour,
  input  tcw_pkg::queue_status_t q_status,
  input  tcw_pkg::cmd_t          head_cmd,
  output logic                   pop,
  output logic                   out_valid,
  output tcw_pkg::out_item_t     out_item
);
  import tcw_pkg::*;
  `include "text_console_writer_assert.svh"

  localparam logic [1:0] ST_EXEC  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_READ  = 2'd3;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_r;

  logic [1:0]        state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic              scroll_r, scroll_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic              wr_copy_r, wr_copy_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, blank;
  logic              copy_now, wrap;
  logic [7:0]        col_inc, col_tab;

  assign blank   = make_cell(CH_SPACE, colour);
  assign col_inc = {1'b0, col_r} + 8'd1;
  assign col_tab = {1'b0, col_r} + 8'(TAB_STEP);
  assign pop     = (state_r == ST_EXEC) && q_status.valid;
  assign copy_now = scroll_r && (idx_r < ADDR_W'(CELLS - COLUMNS));

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    base_nxt      = base_r;
    idx_nxt       = idx_r;
    scroll_nxt    = scroll_r;
    wr_pend_nxt   = 1'b0;
    wr_copy_nxt   = 1'b0;
    wr_addr_nxt   = idx_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    mem_we        = 1'b0;
    mem_waddr     = base_r + ADDR_W'(col_r);
    mem_wdata     = make_cell(head_cmd.character, colour);
    mem_raddr     = copy_now ? idx_r + ADDR_W'(COLUMNS) : head_cmd.cell_address;
    wrap          = 1'b0;

    unique case (state_r)
      ST_EXEC: begin
        if (q_status.valid) begin
          out_valid_nxt = 1'b1;
          unique case (head_cmd.kind)
            CMD_GLYPH: begin
              mem_we = 1'b1;
              if (col_inc >= 8'(COLUMNS)) begin
                wrap = 1'b1;
              end else begin
                col_nxt = col_inc[COL_W-1:0];
              end
            end
            CMD_NEWLINE: begin
              wrap = 1'b1;
            end
            CMD_TAB: begin
              if (col_tab >= 8'(COLUMNS)) begin
                wrap = 1'b1;
              end else begin
                col_nxt = col_tab[COL_W-1:0];
              end
            end
            CMD_CLEAR: begin
              col_nxt       = '0;
              row_nxt       = '0;
              base_nxt      = '0;
              idx_nxt       = '0;
              scroll_nxt    = 1'b0;
              state_nxt     = ST_SWEEP;
              out_valid_nxt = 1'b0;
            end
            CMD_READ: begin
              state_nxt     = ST_READ;
              out_valid_nxt = 1'b0;
            end
            default: begin
            end
          endcase
          if (wrap) begin
            col_nxt = '0;
            if (row_r == ROW_W'(ROWS - 1)) begin
              idx_nxt       = '0;
              scroll_nxt    = 1'b1;
              state_nxt     = ST_SWEEP;
              out_valid_nxt = 1'b0;
            end else begin
              row_nxt  = row_r + ROW_W'(1);
              base_nxt = base_r + ADDR_W'(COLUMNS);
            end
          end
        end
      end
      ST_SWEEP: begin
        wr_pend_nxt = 1'b1;
        wr_copy_nxt = copy_now;
        if (idx_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end
      ST_DRAIN: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_EXEC;
      end
      ST_READ: begin
        out_valid_nxt          = 1'b1;
        out_item_nxt.cell_data = rdata_r;
        state_nxt              = ST_EXEC;
      end
      default: begin
        state_nxt = ST_EXEC;
      end
    endcase

    if (wr_pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr_r;
      mem_wdata = wr_copy_r ? rdata_r : blank;
    end

    out_item_nxt.cursor_column = col_nxt;
    out_item_nxt.cursor_row    = row_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EXEC;
      col_r       <= '0;
      row_r       <= '0;
      base_r      <= '0;
      idx_r       <= '0;
      scroll_r    <= 1'b0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      base_r      <= base_nxt;
      idx_r       <= idx_nxt;
      scroll_r    <= scroll_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_copy_r  <= wr_copy_nxt;
    wr_addr_r  <= wr_addr_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `TCW_ASSERT(a_base_tracks_row, base_r == ADDR_W'(row_r * COLUMNS))
  `TCW_ASSERT(a_col_in_range, col_r < COL_W'(COLUMNS))
  `TCW_NEVER(a_pend_only_in_sweep, wr_pend_r && (state_r == ST_EXEC || state_r == ST_READ))
  `TCW_ASSERT(a_read_answers, state_r == ST_READ |=> out_valid_r)
  `TCW_ASSERT(a_drain_answers, state_r == ST_DRAIN |=> out_valid_r && !wr_pend_r)

endmodule

@@ rtl/text_console_writer.sv @@
// top level of the text console writer: colour registers, front end, queue, executor
// depends on tcw_pkg, tcw_front, tcw_cmd_queue and tcw_back
//
//  channel  handshake         payload            direction
//  input    start / busy      in_item            in
//  result   out_valid strobe  out_item           out
//  config   cfg_we            cfg_index, wdata   in
//
// put, newline, tab, out-of-range or undefined items: EXEC; last-row wraps scroll
// read: EXEC then READ, as the frame store read port is registered
// scroll and clear: SWEEP over all CELLS, then DRAIN; one frame store write per cycle
// busy rises when the two-entry command queue is full; results cannot be stalled
// reset (rst_n low, synchronous) homes the cursor; the frame store is not cleared
module text_console_writer (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  tcw_pkg::in_item_t        in_item,
  output logic                     out_valid,
  output tcw_pkg::out_item_t       out_item,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [tcw_pkg::CLR_W-1:0] cfg_wdata
);
  import tcw_pkg::*;

  colour_t       colour_r, colour_nxt;
  queue_status_t q_status;
  cmd_t          push_cmd, head_cmd;
  logic          push, pop;

  always_comb begin
    colour_nxt = colour_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FOREGROUND: colour_nxt.fg = cfg_wdata;
        CFG_BACKGROUND: colour_nxt.bg = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colour_r.fg <= 4'd15;
      colour_r.bg <= 4'd0;
    end else begin
      colour_r <= colour_nxt;
    end
  end

  tcw_front u_front (
    .start    (start),
    .in_item  (in_item),
    .q_status (q_status),
    .busy     (busy),
    .push     (push),
    .cmd      (push_cmd)
  );

  tcw_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  tcw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .colour    (colour_r),
    .q_status  (q_status),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
